>>> rtl/snr_pkg.sv
package snr_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Field widths
  localparam int SAMPLE_W = 9;
  localparam int THR_W    = 8;
  localparam int SNR_W    = 9;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SUM_W    = $clog2(((1 << SAMPLE_W) - 1) * RING_DEPTH + 1);

  // Reset level of every ring entry and the matching running sum
  localparam logic [SAMPLE_W-1:0] RESET_LEVEL = SAMPLE_W'(320);
  localparam logic [SUM_W-1:0]    SUM_RESET   = SUM_W'(320 * RING_DEPTH);
  localparam logic signed [DIFF_W-1:0] DBM_OFFSET = DIFF_W'(160);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THR = CFG_IDX_W'(1);

  localparam logic signed [THR_W-1:0] OPEN_THR_RESET  = THR_W'(6);
  localparam logic signed [THR_W-1:0] CLOSE_THR_RESET = THR_W'(3);

  // Write port of the sample ring
  typedef struct packed {
    logic                en;
    logic [RING_AW-1:0]  addr;
    logic [SAMPLE_W-1:0] data;
  } ring_wr_t;

  // Squelch thresholds
  typedef struct packed {
    logic signed [THR_W-1:0] open_thr;
    logic signed [THR_W-1:0] close_thr;
  } thr_t;

endpackage

>>> rtl/snr_ring.sv
module snr_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [snr_pkg::RING_AW-1:0]    rd_addr,
  output logic [snr_pkg::SAMPLE_W-1:0]   rd_data,
  input  snr_pkg::ring_wr_t              wr
);
  import snr_pkg::*;

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_vld;

  // Write the entry array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Mark written entries; unwritten entries read as the reset level
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Registered read, forwarding a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      if (wr.en && wr.addr == rd_addr) begin
        rd_vld <= 1'b1;
      end else begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == rd_addr) begin
        rd_q <= wr.data;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : RESET_LEVEL;

endmodule

>>> rtl/snr_update.sv
module snr_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [snr_pkg::SAMPLE_W-1:0]        sample,
  input  logic [snr_pkg::RING_AW-1:0]         slot,
  input  logic [snr_pkg::SAMPLE_W-1:0]        old_level,
  input  snr_pkg::thr_t                       thr,
  output snr_pkg::ring_wr_t                   wr,
  output logic                                is_open,
  output logic [snr_pkg::SAMPLE_W-1:0]        floor_raw,
  output logic signed [snr_pkg::SAMPLE_W-1:0] floor_dbm,
  output logic signed [snr_pkg::SNR_W-1:0]    snr_db
);
  import snr_pkg::*;

  logic [SUM_W-1:0]         ring_sum;
  logic [SUM_W-1:0]         ring_sum_next;
  logic                     open_flag;
  logic                     open_flag_next;
  logic                     take;
  logic [SAMPLE_W-1:0]      floor_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_adj;
  logic signed [DIFF_W-1:0] snr_full;
  logic signed [DIFF_W-1:0] open_thr_x;
  logic signed [DIFF_W-1:0] close_thr_x;
  logic signed [DIFF_W-1:0] dbm_full;

  // Replace the slot when closed, or when open and the sample is lower
  assign take = !open_flag || (sample < old_level);

  assign ring_sum_next = take ? (ring_sum - SUM_W'(old_level) + SUM_W'(sample)) : ring_sum;
  assign floor_next    = SAMPLE_W'(ring_sum_next / RING_DEPTH);

  // Halve the difference, rounding toward zero
  assign diff     = $signed({1'b0, sample}) - $signed({1'b0, floor_next});
  assign diff_adj = diff + $signed({{(DIFF_W-1){1'b0}}, diff[DIFF_W-1]});
  assign snr_full = diff_adj >>> 1;

  assign open_thr_x  = {{(DIFF_W-THR_W){thr.open_thr[THR_W-1]}}, thr.open_thr};
  assign close_thr_x = {{(DIFF_W-THR_W){thr.close_thr[THR_W-1]}}, thr.close_thr};

  // Hysteresis
  always_comb begin
    if (open_flag) begin
      open_flag_next = !(snr_full < close_thr_x);
    end else begin
      open_flag_next = (snr_full >= open_thr_x);
    end
  end

  assign dbm_full = $signed({2'b00, floor_next[SAMPLE_W-1:1]}) - DBM_OFFSET;

  // Ring write-back
  assign wr.en   = fire && take;
  assign wr.addr = slot;
  assign wr.data = sample;

  // Advance the tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sum  <= SUM_RESET;
      open_flag <= 1'b0;
    end else if (fire) begin
      ring_sum  <= ring_sum_next;
      open_flag <= open_flag_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (fire) begin
      is_open   <= open_flag_next;
      floor_raw <= floor_next;
      floor_dbm <= dbm_full[SAMPLE_W-1:0];
      snr_db    <= snr_full[SNR_W-1:0];
    end
  end

endmodule

>>> rtl/snr_squelch_noise_floor_top.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid / in_ready    | rssi_sample
// result  | out       | out_valid / out_ready  | is_open, floor_raw, floor_dbm, snr_db
// config  | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample per cycle sustained while out_ready stays high; the sample and its ring read are
// registered at the accepting edge, then update, write-back and result load follow when the update stage fires.
// Reset is synchronous; the ring needs no clearing pass, per-entry valid bits make
// unwritten slots read as the reset level, so the block is ready right after reset.
// A stalled result holds the update stage; in_ready drops only when both the update
// stage and the result register are full and out_ready is low.
module snr_squelch_noise_floor_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [snr_pkg::SAMPLE_W-1:0]        rssi_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_open,
  output logic [snr_pkg::SAMPLE_W-1:0]        floor_raw,
  output logic signed [snr_pkg::SAMPLE_W-1:0] floor_dbm,
  output logic signed [snr_pkg::SNR_W-1:0]    snr_db,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [snr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [snr_pkg::THR_W-1:0]           cfg_data
);
  import snr_pkg::*;

  logic                in_fire;
  logic                s1_fire;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [RING_AW-1:0]  s1_slot;
  logic [RING_AW-1:0]  write_slot;
  logic [RING_AW-1:0]  write_slot_next;
  logic [SAMPLE_W-1:0] old_level;
  thr_t                thr;
  ring_wr_t            wr;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_fire   = in_valid && in_ready;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.open_thr  <= OPEN_THR_RESET;
      thr.close_thr <= CLOSE_THR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OPEN_THR) begin
        thr.open_thr <= cfg_data;
      end else if (cfg_index == REG_CLOSE_THR) begin
        thr.close_thr <= cfg_data;
      end
    end
  end

  // Advance and wrap the slot pointer
  assign write_slot_next = (write_slot == RING_AW'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (in_fire) begin
      write_slot <= write_slot_next;
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= rssi_sample;
      s1_slot   <= write_slot;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  snr_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (write_slot),
    .rd_data (old_level),
    .wr      (wr)
  );

  snr_update u_update (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .sample    (s1_sample),
    .slot      (s1_slot),
    .old_level (old_level),
    .thr       (thr),
    .wr        (wr),
    .is_open   (is_open),
    .floor_raw (floor_raw),
    .floor_dbm (floor_dbm),
    .snr_db    (snr_db)
  );

endmodule

>>> rtl/snr_checker.sv
module snr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                is_open,
  input logic [snr_pkg::SAMPLE_W-1:0]        floor_raw,
  input logic signed [snr_pkg::SAMPLE_W-1:0] floor_dbm,
  input logic signed [snr_pkg::SNR_W-1:0]    snr_db
);
  import snr_pkg::*;

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Floor in dBm follows the raw floor
  a_dbm_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (floor_dbm == SAMPLE_W'({1'b0, floor_raw[SAMPLE_W-1:1]} - SAMPLE_W'(160))))
    else $error("floor_dbm inconsistent with floor_raw");

  // Halved SNR never reaches the most negative code
  a_snr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (snr_db != {1'b1, {(SNR_W-1){1'b0}}}))
    else $error("snr_db out of range");

  // A stalled beat holds is_open, floor_raw and snr_db
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_open) && $stable(floor_raw)
      && $stable(snr_db))
    else $error("stalled result changed");

endmodule

bind snr_squelch_noise_floor_top snr_checker u_snr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_open   (is_open),
  .floor_raw (floor_raw),
  .floor_dbm (floor_dbm),
  .snr_db    (snr_db)
);
